[rtl/isort_pkg.sv]
// ----------------------------------------------------------------------------
// isort_pkg
// Shared types for the insertion sort engine: controller command and
// datapath status bundles, and the value type.
// ----------------------------------------------------------------------------
package isort_pkg;

  localparam int unsigned ValueWidth = 32;

  typedef logic signed [ValueWidth-1:0] value_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic insert;  // place the incoming value into the store
    logic drop;    // store full, remember that a value was lost
    logic shift;   // head entry taken, move the store down one place
    logic clear;   // set finished, forget the overflow mark
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;        // every entry holds a value
    logic last_entry;  // exactly one entry left to emit
  } status_t;

endpackage

[rtl/isort_dp.sv]
// ----------------------------------------------------------------------------
// isort_dp
// Datapath: a row of sort cells kept in ascending order. Each cell compares
// its entry with the incoming value in parallel. Results leave from cell 0
// while the row shifts down.
// ----------------------------------------------------------------------------
module isort_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  isort_pkg::cmd_t    cmd,
  input  isort_pkg::value_t  in_value,
  output isort_pkg::status_t status,
  output isort_pkg::value_t  head_value,
  output logic               dropped
);

  localparam int unsigned CntWidth = $clog2(CAPACITY + 1);

  isort_pkg::value_t   store_r [CAPACITY];
  isort_pkg::value_t   store_nxt [CAPACITY];
  logic [CAPACITY-1:0] greater;
  logic [CntWidth-1:0] count_r;
  logic [CntWidth-1:0] count_nxt;
  logic                dropped_r;
  logic                dropped_nxt;

  // a valid entry strictly greater than the new value moves up one place,
  // so equal values keep arrival order
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic valid;
    logic keep;
    logic from_below;

    assign valid      = CntWidth'(i) < count_r;
    assign greater[i] = valid && (store_r[i] > in_value);
    assign keep       = valid && !greater[i];
    if (i == 0) begin : g_head
      assign from_below = 1'b0;
    end else begin : g_body
      assign from_below = greater[i-1];
    end

    always_comb begin
      store_nxt[i] = store_r[i];
      if (cmd.insert && !keep && (CntWidth'(i) <= count_r)) begin
        store_nxt[i] = from_below ? store_r[(i > 0) ? i - 1 : 0] : in_value;
      end else if (cmd.shift && (i < CAPACITY - 1)) begin
        store_nxt[i] = store_r[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk) begin
      store_r[i] <= store_nxt[i];
    end
  end

  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    if (cmd.insert) begin
      count_nxt = count_r + CntWidth'(1);
    end else if (cmd.shift) begin
      count_nxt = count_r - CntWidth'(1);
    end
    if (cmd.drop) begin
      dropped_nxt = 1'b1;
    end else if (cmd.clear) begin
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign status.full       = count_r == CntWidth'(CAPACITY);
  assign status.last_entry = count_r == CntWidth'(1);
  assign head_value        = store_r[0];
  assign dropped           = dropped_r;

endmodule

[rtl/isort_ctrl.sv]
// ----------------------------------------------------------------------------
// isort_ctrl
// Controller: collects values until the last one of a set, then streams the
// sorted set out one transaction at a time.
// ----------------------------------------------------------------------------
module isort_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tlast,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  isort_pkg::status_t status,
  output isort_pkg::cmd_t    cmd
);

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;
  logic   out_fire;

  assign in_tready  = state_r == ST_COLLECT;
  assign out_tvalid = state_r == ST_EMIT;
  assign in_fire    = in_tvalid && in_tready;
  assign out_fire   = out_tvalid && out_tready;

  always_comb begin
    cmd        = '0;
    cmd.insert = in_fire && !status.full;
    cmd.drop   = in_fire && status.full;
    cmd.shift  = out_fire;
    cmd.clear  = out_fire && status.last_entry;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: begin
        if (in_fire && in_tlast) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_fire && status.last_entry) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/insertion_sort_engine.sv]
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Streaming insertion sorter for signed 32-bit values.
// ----------------------------------------------------------------------------
// Values arrive one per input transaction and are placed in ascending order
// in a row of CAPACITY compare cells; equal values keep their arrival order.
// While a set is being collected the block takes one value every cycle, as
// all cells compare against the new value at once. The value marked with
// in_tlast closes the set: the sorted values then leave smallest first, one
// per output transaction, the largest with out_tlast set, so a set holds
// the input off until its largest value has left. Values arriving with the
// store full are dropped and every result of that set carries out_tuser
// high. After the last result the store is empty again.
// ----------------------------------------------------------------------------
module insertion_sort_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,  // end_of_set
  output logic        out_tuser   // [0] overflow
);

  isort_pkg::cmd_t    cmd;
  isort_pkg::status_t status;
  isort_pkg::value_t  head_value;
  logic               dropped;

  isort_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  isort_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_value   ($signed(in_tdata)),
    .status     (status),
    .head_value (head_value),
    .dropped    (dropped)
  );

  assign out_tdata = $unsigned(head_value);
  assign out_tlast = status.last_entry;
  assign out_tuser = dropped;

endmodule
